// ----- design/sfa_pkg.sv -----
// ----------------------------------------------------------------------------
// sfa_pkg: shared types and constants for the secp256k1 field ALU
// Prime modulus, fold constant, inversion exponent and operation codes.
// ----------------------------------------------------------------------------
package sfa_pkg;

    localparam logic [255:0] PRIME   = {64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF,
                                        64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFEFFFFFC2F};
    localparam logic [255:0] EXP_INV = {64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF,
                                        64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFEFFFFFC2D};
    localparam logic [63:0]  FOLD_C  = 64'h00000001000003D1;
    // low part of the fold constant, 2^256 = 2^32 + 977 (mod p)
    localparam logic [9:0]   FOLD_LOW = 10'd977;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_NEG = 3'd2,
        OP_MUL = 3'd3,
        OP_SQR = 3'd4,
        OP_INV = 3'd5
    } op_t;

endpackage

// ----- design/secp256k1_field_alu_unit.sv -----
// ----------------------------------------------------------------------------
// secp256k1_field_alu_unit: modular arithmetic over p = 2^256 - 2^32 - 977
// Add, subtract, negate, multiply, square and invert with one shared
// 32x32 multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// Timing: one request at a time. Add, subtract, negate and unknown codes pass
// through operand reduction (S_REDA, S_REDB), setup (S_FIX) and S_ALU to a
// valid result. A multiply or square runs operand reduction and setup,
// sixty-four 32x32 partial products through the single shared multiplier,
// four fold steps and three small top folds (each a shift plus a multiply by
// 977), a final subtraction and a hand-off state. Invert runs 256 squarings
// plus 249 multiplies on the same path. The result register holds
// the answer until taken; a new request is accepted once the result leaves.
module secp256k1_field_alu_unit
    import sfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  req_type,
    input  logic [63:0] a_limb0,
    input  logic [63:0] a_limb1,
    input  logic [63:0] a_limb2,
    input  logic [63:0] a_limb3,
    input  logic [63:0] b_limb0,
    input  logic [63:0] b_limb1,
    input  logic [63:0] b_limb2,
    input  logic [63:0] b_limb3,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] r_limb0,
    output logic [63:0] r_limb1,
    output logic [63:0] r_limb2,
    output logic [63:0] r_limb3
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_REDA  = 11'b00000000010,
        S_REDB  = 11'b00000000100,
        S_ALU   = 11'b00000001000,
        S_PROD  = 11'b00000010000,
        S_FOLD  = 11'b00000100000,
        S_TOP   = 11'b00001000000,
        S_FINAL = 11'b00010000000,
        S_MDONE = 11'b00100000000,
        S_DONE  = 11'b01000000000,
        S_FIX   = 11'b10000000000
    } state_t;

    state_t        state_reg, state_next;
    logic [2:0]    op_reg;
    logic [255:0]  a_reg, b_reg, acc_reg, x_reg, y_reg, res_reg;
    logic [511:0]  w_reg;
    logic [319:0]  t_reg;
    logic [5:0]    pp_reg;     // partial product index i*8+j over 32-bit halves
    logic [1:0]    cnt_reg;    // fold / top-fold counter
    logic [7:0]    bit_reg;    // exponent bit index
    logic          inv_mul_reg; // 1: current multiply is acc*a
    logic          inv_reg;    // running an inversion

    // shared multiplier
    logic [31:0]   mx, my;
    logic [63:0]   mprod;
    assign mprod = mx * my;

    logic [2:0] pi, pj;
    assign pi = pp_reg[5:3];
    assign pj = pp_reg[2:0];

    always_comb
    begin
        mx = 32'd0;
        my = 32'd0;
        if (state_reg == S_PROD)
        begin
            mx = x_reg[pi*32 +: 32];
            my = y_reg[pj*32 +: 32];
        end
    end

    // h * (2^32 + 977) as a shift plus a small constant multiply
    logic [63:0]  fold_h;
    logic [73:0]  fold_m;
    logic [97:0]  fold_p;
    assign fold_h = (state_reg == S_FOLD) ? w_reg[256 + cnt_reg*64 +: 64]
                                          : t_reg[319:256];
    assign fold_m = fold_h * FOLD_LOW;
    assign fold_p = {2'd0, fold_h, 32'd0} + {24'd0, fold_m};

    // reduce-once helper
    function automatic logic [255:0] red1(input logic [255:0] v);
        logic [256:0] d;
        d = {1'b0, v} - {1'b0, PRIME};
        return d[256] ? v : d[255:0];
    endfunction

    logic [256:0] sum_w, dif_w;
    logic [255:0] alu_w;
    logic [255:0] lhs_w;
    always_comb
    begin
        lhs_w = (op_reg == OP_NEG) ? 256'd0 : a_reg;
        sum_w = {1'b0, a_reg} + {1'b0, b_reg};
        dif_w = {1'b0, lhs_w} - {1'b0, (op_reg == OP_NEG) ? a_reg : b_reg};
        alu_w = 256'd0;
        case (op_reg) inside
            OP_ADD: alu_w = sum_w[256] ? (sum_w[255:0] - PRIME) : red1(sum_w[255:0]);
            OP_SUB, OP_NEG: alu_w = dif_w[256] ? (dif_w[255:0] + PRIME) : dif_w[255:0];
            default: alu_w = 256'd0;
        endcase
    end

    // accumulate one partial product into w at half-limb i+j
    logic [511:0] pp_add;
    logic [319:0] fold_add, top_add;
    assign pp_add   = {448'd0, mprod} << ((pi + pj) * 32);
    assign fold_add = {222'd0, fold_p} << (cnt_reg * 64);
    assign top_add  = {222'd0, fold_p};

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_DONE);
    assign r_limb0   = res_reg[63:0];
    assign r_limb1   = res_reg[127:64];
    assign r_limb2   = res_reg[191:128];
    assign r_limb3   = res_reg[255:192];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_REDA;
            S_REDA:  state_next = S_REDB;
            S_REDB:  state_next = S_FIX;
            S_FIX:   state_next = (op_reg == OP_MUL || op_reg == OP_SQR ||
                                   op_reg == OP_INV) ? S_PROD : S_ALU;
            S_ALU:   state_next = S_DONE;
            S_PROD:  if (pp_reg == 6'd63) state_next = S_FOLD;
            S_FOLD:  if (cnt_reg == 2'd3) state_next = S_TOP;
            S_TOP:   if (cnt_reg == 2'd2) state_next = S_FINAL;
            S_FINAL: state_next = S_MDONE;
            S_MDONE: state_next = (inv_reg && !(bit_reg == 8'd0 && !inv_mul_reg &&
                                   !EXP_INV[0]) && !(bit_reg == 8'd0 && inv_mul_reg))
                                  ? S_PROD : S_DONE;
            S_DONE:  if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_reg <= req_type;
                    a_reg  <= {a_limb3, a_limb2, a_limb1, a_limb0};
                    b_reg  <= {b_limb3, b_limb2, b_limb1, b_limb0};
                end
            end
            S_REDA: a_reg <= red1(a_reg);
            S_REDB: b_reg <= red1(b_reg);
            S_FIX:
            begin
                inv_reg     <= (op_reg == OP_INV);
                inv_mul_reg <= 1'b0;
                bit_reg     <= 8'd255;
                acc_reg     <= 256'd1;
                x_reg       <= (op_reg == OP_INV) ? 256'd1 : a_reg;
                y_reg       <= (op_reg == OP_MUL) ? b_reg :
                               (op_reg == OP_INV) ? 256'd1 : a_reg;
                w_reg       <= 512'd0;
                pp_reg      <= 6'd0;
                cnt_reg     <= 2'd0;
            end
            S_ALU:
                res_reg <= (op_reg == OP_ADD || op_reg == OP_SUB || op_reg == OP_NEG)
                           ? alu_w : 256'd0;
            S_PROD:
            begin
                w_reg  <= w_reg + pp_add;
                pp_reg <= pp_reg + 6'd1;
                // the last product lands above bit 255, low half is final
                if (pp_reg == 6'd63)
                    t_reg <= {64'd0, w_reg[255:0]};
            end
            S_FOLD:
            begin
                t_reg   <= t_reg + fold_add;
                cnt_reg <= cnt_reg + 2'd1;
            end
            S_TOP:
            begin
                t_reg   <= {64'd0, t_reg[255:0]} + top_add;
                cnt_reg <= (cnt_reg == 2'd2) ? 2'd0 : cnt_reg + 2'd1;
            end
            S_FINAL: acc_reg <= red1(t_reg[255:0]);
            S_MDONE:
            begin
                w_reg  <= 512'd0;
                pp_reg <= 6'd0;
                if (!inv_reg)
                    res_reg <= acc_reg;
                else if (!inv_mul_reg && EXP_INV[bit_reg])
                begin
                    inv_mul_reg <= 1'b1;
                    x_reg       <= acc_reg;
                    y_reg       <= a_reg;
                end
                else if (bit_reg == 8'd0)
                    res_reg <= acc_reg;
                else
                begin
                    inv_mul_reg <= 1'b0;
                    bit_reg     <= bit_reg - 8'd1;
                    x_reg       <= acc_reg;
                    y_reg       <= acc_reg;
                end
            end
            S_DONE: ;
            default: ;
        endcase
    end

endmodule

// ----- design/sfa_checker.sv -----
// ----------------------------------------------------------------------------
// sfa_checker: port-level checks for the field ALU
// Watches the handshake and result range on the top level ports.
// ----------------------------------------------------------------------------
module sfa_checker
    import sfa_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] r_limb0,
    input logic [63:0] r_limb1,
    input logic [63:0] r_limb2,
    input logic [63:0] r_limb3
);

    // a pending result keeps its value in limbs 0 and 3
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(r_limb0) && $stable(r_limb3))
        else $error("result changed while stalled");

    // never ready and holding a result at once
    assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
        else $error("ready while result pending");

    // an accepted request is not followed by an immediate result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid)
        else $error("result too early");

    // results are reduced below p
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({r_limb3, r_limb2, r_limb1, r_limb0} < PRIME))
        else $error("result not reduced");

endmodule

bind secp256k1_field_alu_unit sfa_checker u_sfa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .r_limb0   (r_limb0),
    .r_limb1   (r_limb1),
    .r_limb2   (r_limb2),
    .r_limb3   (r_limb3)
);

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for secp256k1_field_alu_unit
// Directed table of corner requests followed by random requests across all
// operations. Each result is compared limb by limb against a modular
// arithmetic predictor, with random input gaps and random out_ready stalls.
// ----------------------------------------------------------------------------
module testbench;
    import sfa_pkg::*;

    localparam int NUM_RANDOM  = 1330;
    localparam int QUIET_TAIL  = 150;
    localparam int STALL_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 40;

    typedef struct {
        logic [2:0]   op;
        logic [255:0] a;
        logic [255:0] b;
        bit           typed;
        logic [255:0] res;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  req_type;
    logic [63:0] a_limb0, a_limb1, a_limb2, a_limb3;
    logic [63:0] b_limb0, b_limb1, b_limb2, b_limb3;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] r_limb0, r_limb1, r_limb2, r_limb3;

    logic [255:0] expected_q[$];
    int           errors;
    int           idle_cycles;
    bit           quiet;
    bit           out_acc;
    logic [255:0] ones;

    secp256k1_field_alu_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .a_limb0   (a_limb0),
        .a_limb1   (a_limb1),
        .a_limb2   (a_limb2),
        .a_limb3   (a_limb3),
        .b_limb0   (b_limb0),
        .b_limb1   (b_limb1),
        .b_limb2   (b_limb2),
        .b_limb3   (b_limb3),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .r_limb0   (r_limb0),
        .r_limb1   (r_limb1),
        .r_limb2   (r_limb2),
        .r_limb3   (r_limb3)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic logic [255:0] to_residue(logic [255:0] x);
        return (x >= PRIME) ? x - PRIME : x;
    endfunction

    function automatic logic [255:0] mod_mul(logic [255:0] x, logic [255:0] y);
        logic [511:0] prod;
        prod = {256'd0, x} * {256'd0, y};
        return 256'(prod % {256'd0, PRIME});
    endfunction

    function automatic logic [255:0] field_result(logic [2:0] op, logic [255:0] a_in,
                                                 logic [255:0] b_in);
        logic [255:0] a;
        logic [255:0] b;
        logic [256:0] sum;
        logic [255:0] acc;
        a = to_residue(a_in);
        b = to_residue(b_in);
        case (op)
            OP_ADD:
            begin
                sum = {1'b0, a} + {1'b0, b};
                if (sum >= {1'b0, PRIME})
                    sum = sum - {1'b0, PRIME};
                return sum[255:0];
            end
            OP_SUB: return (a >= b) ? a - b : a - b + PRIME;
            OP_NEG: return (a == 256'd0) ? 256'd0 : PRIME - a;
            OP_MUL: return mod_mul(a, b);
            OP_SQR: return mod_mul(a, a);
            OP_INV:
            begin
                // Fermat: a^(p-2), zero stays zero
                acc = 256'd1;
                for (int i = 255; i >= 0; i--)
                begin
                    acc = mod_mul(acc, acc);
                    if (EXP_INV[i])
                        acc = mod_mul(acc, a);
                end
                return acc;
            end
            default: return 256'd0;
        endcase
    endfunction

    function automatic logic [255:0] rand_wide();
        return {$urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic logic [255:0] rand_operand();
        logic [255:0] small_val;
        small_val = 256'($urandom_range(0, 1000));
        case ($urandom_range(0, 11))
            0: return 256'd0;
            1: return small_val;
            2: return PRIME - 256'd1 - small_val;
            3: return PRIME + small_val;       // unreduced, still fits
            4: return {256{1'b1}};
            default: return rand_wide();
        endcase
    endfunction

    function automatic logic [2:0] rand_op();
        int pick;
        pick = $urandom_range(0, 199);
        if (pick < 2)
            return OP_INV;
        if (pick < 6)
            return 3'($urandom_range(6, 7));   // undefined codes
        case (pick % 5)
            0: return OP_ADD;
            1: return OP_SUB;
            2: return OP_NEG;
            3: return OP_MUL;
            default: return OP_SQR;
        endcase
    endfunction

    // drive at the falling edge, wait for acceptance at a rising edge
    task automatic send_request(logic [2:0] op, logic [255:0] a, logic [255:0] b,
                                logic [255:0] res);
        @(negedge clk);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid = 1'b1;
        req_type = op;
        {a_limb3, a_limb2, a_limb1, a_limb0} = a;
        {b_limb3, b_limb2, b_limb1, b_limb0} = b;
        do
            @(posedge clk);
        while (!in_ready);
        expected_q.push_back(res);
    endtask

    // out_ready: random stall bursts, none in the tail
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 4) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 6) - 1) @(negedge clk);
            end
            else
                out_ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        logic [255:0] want;
        out_acc = out_valid && out_ready && rst_n;
        if (out_acc)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result with no request pending: %h",
                       {r_limb3, r_limb2, r_limb1, r_limb0});
                errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (r_limb0 !== want[63:0])
                begin
                    $error("r_limb0 exp %h got %h", want[63:0], r_limb0);
                    errors++;
                end
                if (r_limb1 !== want[127:64])
                begin
                    $error("r_limb1 exp %h got %h", want[127:64], r_limb1);
                    errors++;
                end
                if (r_limb2 !== want[191:128])
                begin
                    $error("r_limb2 exp %h got %h", want[191:128], r_limb2);
                    errors++;
                end
                if (r_limb3 !== want[255:192])
                begin
                    $error("r_limb3 exp %h got %h", want[255:192], r_limb3);
                    errors++;
                end
            end
        end
    end

    // watchdog: cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        row_t         dir_rows[16];
        logic [2:0]   op;
        logic [255:0] a;
        logic [255:0] b;
        logic [255:0] want;

        ones        = {256{1'b1}};
        errors      = 0;
        idle_cycles = 0;
        quiet       = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        req_type    = OP_ADD;
        {a_limb3, a_limb2, a_limb1, a_limb0} = 256'd0;
        {b_limb3, b_limb2, b_limb1, b_limb0} = 256'd0;

        dir_rows[0]  = '{OP_ADD, 256'd0,              256'd0,        1, 256'd0};
        dir_rows[1]  = '{OP_ADD, PRIME - 256'd1,      256'd1,        1, 256'd0};
        dir_rows[2]  = '{OP_SUB, 256'd0,              256'd1,        1, PRIME - 256'd1};
        dir_rows[3]  = '{OP_SUB, 256'd7,              256'd7,        1, 256'd0};
        dir_rows[4]  = '{OP_NEG, 256'd0,              ones,          1, 256'd0};
        dir_rows[5]  = '{OP_NEG, 256'd1,              256'd0,        1, PRIME - 256'd1};
        dir_rows[6]  = '{OP_MUL, PRIME - 256'd1,      PRIME - 256'd1, 1, 256'd1};
        dir_rows[7]  = '{OP_MUL, ones,                ones,          0, 256'd0};
        dir_rows[8]  = '{OP_SQR, ones,                256'd0,        0, 256'd0};
        dir_rows[9]  = '{OP_ADD, PRIME,               256'd5,        1, 256'd5};
        dir_rows[10] = '{OP_ADD, ones,                ones,          0, 256'd0};
        dir_rows[11] = '{OP_INV, 256'd0,              ones,          1, 256'd0};
        dir_rows[12] = '{OP_INV, 256'd1,              256'd0,        1, 256'd1};
        dir_rows[13] = '{OP_INV, PRIME + 256'd2,      256'd0,        0, 256'd0};
        dir_rows[14] = '{3'd6,   ones,                ones,          1, 256'd0};
        dir_rows[15] = '{3'd7,   rand_wide(),         rand_wide(),   1, 256'd0};

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
        begin
            want = dir_rows[i].typed ? dir_rows[i].res
                 : field_result(dir_rows[i].op, dir_rows[i].a, dir_rows[i].b);
            send_request(dir_rows[i].op, dir_rows[i].a, dir_rows[i].b, want);
        end

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            if (n >= NUM_RANDOM - QUIET_TAIL)
                quiet = 1'b1;
            op = rand_op();
            a  = rand_operand();
            b  = rand_operand();
            send_request(op, a, b, field_result(op, a, b));
        end

        @(negedge clk);
        in_valid = 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (errors == 0 && expected_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
